// ----- design/tfi_pkg.sv -----
package tfi_pkg;

   // Fixed field widths.
   localparam int PosW      = 32;
   localparam int FieldW    = 24;
   localparam int FracW     = 16;
   localparam int WeightW   = 17;
   localparam int AddrW     = 16;
   localparam int StoreDepth = 65536;
   localparam int CsrIdxW   = 3;
   localparam int CsrDataW  = 32;
   localparam int Corners   = 8;
   // Blend intermediates: values in Q16 and their products with a weight.
   localparam int LerpW     = 41;
   localparam int ProdW     = 59;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_QUERY = 1'b1
   } opcode_type;

   typedef logic signed [FieldW-1:0] field_type;
   typedef logic [WeightW-1:0] weight_type;
   typedef logic [AddrW-1:0] addr_type;

   // Register indexes of the configuration port.
   localparam logic [CsrIdxW-1:0] CSR_ORIGIN_X = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_ORIGIN_Y = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_ORIGIN_Z = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_RECIP_X  = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_RECIP_Y  = 3'd4;
   localparam logic [CsrIdxW-1:0] CSR_RECIP_Z  = 3'd5;

   localparam logic [CsrDataW-1:0] RECIP_RESET = 32'd167772;

   // One linear blend a*(1-w) + b*w with w in 16 fraction bits.
   function automatic logic signed [ProdW-1:0] lerp(input logic signed [LerpW-1:0] a,
                                                   input logic signed [LerpW-1:0] b,
                                                   input weight_type w);
      logic signed [WeightW:0] wb;
      logic signed [WeightW:0] wa;
      logic signed [ProdW-1:0] pa;
      logic signed [ProdW-1:0] pb;
      wb = $signed({1'b0, w});
      wa = $signed(18'h10000) - wb;
      pa = a * wa;
      pb = b * wb;
      return pa + pb;
   endfunction

endpackage

// ----- design/tfi_if.sv -----
interface tfi_req_if import tfi_pkg::*; ();
   logic       valid;
   logic       ready;
   opcode_type opcode;
   logic signed [PosW-1:0] pos_x;
   logic signed [PosW-1:0] pos_y;
   logic signed [PosW-1:0] pos_z;
   logic [AddrW-1:0] entry_index;
   field_type  write_bx;
   field_type  write_by;
   field_type  write_bz;

   modport source (output valid, opcode, pos_x, pos_y, pos_z, entry_index,
                   write_bx, write_by, write_bz, input ready);
   modport sink (input valid, opcode, pos_x, pos_y, pos_z, entry_index,
                 write_bx, write_by, write_bz, output ready);
endinterface

interface tfi_rsp_if import tfi_pkg::*; ();
   logic      valid;
   logic      ready;
   field_type field_x;
   field_type field_y;
   field_type field_z;

   modport source (output valid, field_x, field_y, field_z, input ready);
   modport sink (input valid, field_x, field_y, field_z, output ready);
endinterface

// ----- design/tfi_axis.sv -----
module tfi_axis import tfi_pkg::*; #(
   parameter int N = 32
) (
   input  logic                     clock,
   input  logic                     adv,
   input  logic signed [PosW-1:0]   pos,
   input  logic signed [PosW-1:0]   origin,
   input  logic [PosW-1:0]          recip,
   output logic [$clog2(N)-1:0]     base,
   output weight_type               weight
);
   localparam int CW = $clog2(N);
   localparam int FW = 2 * PosW - FracW;
   localparam logic [FW-1:0] TOP = FW'(N - 1) << FracW;

   logic signed [PosW:0] diff_ff, diff_in;
   logic [FW-1:0] grid_ff, grid_in;
   logic [2*PosW-1:0] prod;
   logic [FW-1:0] clamped;
   logic at_top;
   logic [CW-1:0] base_ff, base_in;
   weight_type weight_ff, weight_in;

   // Offset from the grid start.
   assign diff_in = (PosW+1)'(pos) - (PosW+1)'(origin);

   // Scale to Q16 grid units; a point below the origin sits at zero.
   assign prod = diff_ff[PosW-1:0] * recip;
   assign grid_in = (diff_ff > 0) ? prod[2*PosW-1:FracW] : '0;

   // Clamp to the last grid line and keep the lower cell below it.
   assign clamped = (grid_ff > TOP) ? TOP : grid_ff;
   assign at_top = (clamped[FW-1:FracW] >= (FW-FracW)'(N - 1));
   assign base_in = at_top ? CW'(N - 2) : clamped[FracW+CW-1:FracW];
   assign weight_in = at_top ? WeightW'(1 << FracW) : {1'b0, clamped[FracW-1:0]};

   always_ff @(posedge clock) begin
      if (adv) begin
         diff_ff <= diff_in;
         grid_ff <= grid_in;
         base_ff <= base_in;
         weight_ff <= weight_in;
      end
   end

   assign base = base_ff;
   assign weight = weight_ff;
endmodule

// ----- design/tfi_bank.sv -----
module tfi_bank import tfi_pkg::*; (
   input  logic                  clock,
   input  logic                  adv,
   input  logic                  wr_en,
   input  addr_type              wr_addr,
   input  logic [3*FieldW-1:0]   wr_data,
   input  addr_type              rd_addr,
   output logic [3*FieldW-1:0]   rd_data
);
   logic [3*FieldW-1:0] mem [StoreDepth];
   logic [3*FieldW-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- design/tfi_blend.sv -----
module tfi_blend import tfi_pkg::*; (
   input  logic       clock,
   input  logic       adv,
   input  field_type  corner [Corners],
   input  weight_type wx,
   input  weight_type wy,
   input  weight_type wz,
   output field_type  result
);
   logic signed [LerpW-1:0] z_ff [4];
   logic signed [LerpW-1:0] z_in [4];
   logic signed [LerpW-1:0] y_ff [2];
   logic signed [LerpW-1:0] y_in [2];
   logic signed [ProdW-1:0] y_sum [2];
   logic signed [ProdW-1:0] x_sum;
   weight_type wy_ff, wx_ff, wx2_ff;
   field_type result_ff, result_in;

   // Blend along z: exact Q16.
   for (genvar j = 0; j < 4; j++) begin : g_z
      logic signed [ProdW-1:0] zl;
      assign zl = lerp(LerpW'(corner[2*j]), LerpW'(corner[2*j+1]), wz);
      assign z_in[j] = zl[LerpW-1:0];
   end

   // Blend along y, then round to Q16.
   for (genvar j = 0; j < 2; j++) begin : g_y
      assign y_sum[j] = lerp(z_ff[2*j], z_ff[2*j+1], wy_ff) + ProdW'(1 << (FracW - 1));
      assign y_in[j] = y_sum[j][LerpW+FracW-1:FracW];
   end

   // Blend along x, then round to an integer code.
   assign x_sum = lerp(y_ff[0], y_ff[1], wx2_ff) + (ProdW'(1) << (2 * FracW - 1));
   assign result_in = x_sum[FieldW+2*FracW-1:2*FracW];

   always_ff @(posedge clock) begin
      if (adv) begin
         z_ff <= z_in;
         wy_ff <= wy;
         wx_ff <= wx;
         y_ff <= y_in;
         wx2_ff <= wx_ff;
         result_ff <= result_in;
      end
   end

   assign result = result_ff;
endmodule

// ----- design/trilinear_field_interpolation.sv -----
// Trilinear interpolation of a field vector stored on a 3-D grid.
// The request channel carries two kinds of items. A write stores one vector
// at a flat grid address and gives no response. A query gives a position;
// the block returns one response with the vector blended from the eight
// grid corners around it.
// The user must write origins and reciprocal spacings on the csr port only
// while the block is idle; the block itself does not enforce this. Each write
// takes effect at the next clock edge. A request is taken every cycle while the
// skid register is empty. A query's transfer edge loads the first of nine
// registers: three to scale and clamp the position, one to form the corner
// addresses, one for the registered read of the eight store copies (one copy
// per corner, each written by every write item), three for the z, y and x
// blends, and the output register. Writes and queries pass the store stage in
// order, so a query sees every write accepted before it.
// When the receiver stalls, one more response is caught in a skid register
// and req.ready then drops until the skid register drains; nothing is lost
// or repeated. Reset clears the pipeline valid bits and restores the
// configuration registers; the grid store itself is not cleared.
module trilinear_field_interpolation import tfi_pkg::*; #(
   parameter int GRID_X = 32,
   parameter int GRID_Y = 32,
   parameter int GRID_Z = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CsrIdxW-1:0]   csr_index,
   input  logic [CsrDataW-1:0]  csr_wdata,
   tfi_req_if.sink              req_chan,
   tfi_rsp_if.source            rsp_chan
);
   localparam int XW = $clog2(GRID_X);
   localparam int YW = $clog2(GRID_Y);
   localparam int ZW = $clog2(GRID_Z);

   logic signed [PosW-1:0] origin_x_ff, origin_y_ff, origin_z_ff;
   logic [PosW-1:0] recip_x_ff, recip_y_ff, recip_z_ff;

   logic adv;
   logic accept;
   logic [7:0] vld_ff, vld_in;
   opcode_type op_ff [4];
   addr_type idx_ff [4];
   logic [3*FieldW-1:0] wdata_ff [4];
   logic [XW-1:0] cell_x;
   logic [YW-1:0] cell_y;
   logic [ZW-1:0] cell_z;
   weight_type wx3, wy3, wz3;
   weight_type wx4_ff, wy4_ff, wz4_ff, wx5_ff, wy5_ff, wz5_ff;
   addr_type addr_in [Corners];
   addr_type addr_ff [Corners];
   logic [3*FieldW-1:0] rd_data [Corners];
   field_type corner_x [Corners];
   field_type corner_y [Corners];
   field_type corner_z [Corners];
   logic store_we;
   field_type res_x, res_y, res_z;
   logic out_vld_ff, skid_vld_ff;
   field_type out_x_ff, out_y_ff, out_z_ff, skid_x_ff, skid_y_ff, skid_z_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         origin_z_ff <= '0;
         recip_x_ff <= RECIP_RESET;
         recip_y_ff <= RECIP_RESET;
         recip_z_ff <= RECIP_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ORIGIN_X: origin_x_ff <= $signed(csr_wdata);
            CSR_ORIGIN_Y: origin_y_ff <= $signed(csr_wdata);
            CSR_ORIGIN_Z: origin_z_ff <= $signed(csr_wdata);
            CSR_RECIP_X: recip_x_ff <= csr_wdata;
            CSR_RECIP_Y: recip_y_ff <= csr_wdata;
            CSR_RECIP_Z: recip_z_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // The whole pipeline moves unless the skid register is holding a response.
   assign adv = !skid_vld_ff;
   assign req_chan.ready = adv;
   assign accept = req_chan.valid && req_chan.ready;

   // Valid bits; writes leave the pipeline at the store stage.
   always_comb begin
      vld_in = {vld_ff[6:4], vld_ff[3] && (op_ff[3] == OP_QUERY), vld_ff[2:0], accept};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // Opcode and write payload travel alongside the position stages.
   always_ff @(posedge clock) begin
      if (adv) begin
         op_ff[0] <= req_chan.opcode;
         idx_ff[0] <= req_chan.entry_index;
         wdata_ff[0] <= {req_chan.write_bx, req_chan.write_by, req_chan.write_bz};
         for (int s = 1; s < 4; s++) begin
            op_ff[s] <= op_ff[s-1];
            idx_ff[s] <= idx_ff[s-1];
            wdata_ff[s] <= wdata_ff[s-1];
         end
      end
   end

   // Per-axis scaling, clamping and weights.
   tfi_axis #(.N(GRID_X)) u_axis_x (
      .clock(clock), .adv(adv), .pos(req_chan.pos_x), .origin(origin_x_ff),
      .recip(recip_x_ff), .base(cell_x), .weight(wx3)
   );
   tfi_axis #(.N(GRID_Y)) u_axis_y (
      .clock(clock), .adv(adv), .pos(req_chan.pos_y), .origin(origin_y_ff),
      .recip(recip_y_ff), .base(cell_y), .weight(wy3)
   );
   tfi_axis #(.N(GRID_Z)) u_axis_z (
      .clock(clock), .adv(adv), .pos(req_chan.pos_z), .origin(origin_z_ff),
      .recip(recip_z_ff), .base(cell_z), .weight(wz3)
   );

   // Corner addresses, wrapped to the store size; z is the fastest corner bit.
   for (genvar k = 0; k < Corners; k++) begin : g_addr
      assign addr_in[k] = ((AddrW'(cell_x) + AddrW'((k >> 2) & 1)) * AddrW'(GRID_Y)
                           + AddrW'(cell_y) + AddrW'((k >> 1) & 1)) * AddrW'(GRID_Z)
                          + AddrW'(cell_z) + AddrW'(k & 1);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         addr_ff <= addr_in;
         wx4_ff <= wx3;
         wy4_ff <= wy3;
         wz4_ff <= wz3;
         wx5_ff <= wx4_ff;
         wy5_ff <= wy4_ff;
         wz5_ff <= wz4_ff;
      end
   end

   // One store copy per corner; every write item updates all of them.
   assign store_we = adv && vld_ff[3] && (op_ff[3] == OP_WRITE);

   for (genvar k = 0; k < Corners; k++) begin : g_bank
      tfi_bank u_bank (
         .clock(clock), .adv(adv), .wr_en(store_we), .wr_addr(idx_ff[3]),
         .wr_data(wdata_ff[3]), .rd_addr(addr_ff[k]), .rd_data(rd_data[k])
      );
      assign corner_x[k] = rd_data[k][3*FieldW-1:2*FieldW];
      assign corner_y[k] = rd_data[k][2*FieldW-1:FieldW];
      assign corner_z[k] = rd_data[k][FieldW-1:0];
   end

   // Trilinear blend of each component.
   tfi_blend u_blend_x (
      .clock(clock), .adv(adv), .corner(corner_x), .wx(wx5_ff), .wy(wy5_ff),
      .wz(wz5_ff), .result(res_x)
   );
   tfi_blend u_blend_y (
      .clock(clock), .adv(adv), .corner(corner_y), .wx(wx5_ff), .wy(wy5_ff),
      .wz(wz5_ff), .result(res_y)
   );
   tfi_blend u_blend_z (
      .clock(clock), .adv(adv), .corner(corner_z), .wx(wx5_ff), .wy(wy5_ff),
      .wz(wz5_ff), .result(res_z)
   );

   // Output register with a skid register behind it.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         priority if (out_vld_ff && rsp_chan.ready) begin
            if (skid_vld_ff) begin
               skid_vld_ff <= 1'b0;
            end else begin
               out_vld_ff <= adv && vld_ff[7];
            end
         end else if (!out_vld_ff) begin
            out_vld_ff <= adv && vld_ff[7];
         end else begin
            if (adv && vld_ff[7]) begin
               skid_vld_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      priority if (out_vld_ff && rsp_chan.ready && skid_vld_ff) begin
         out_x_ff <= skid_x_ff;
         out_y_ff <= skid_y_ff;
         out_z_ff <= skid_z_ff;
      end else if (!out_vld_ff || rsp_chan.ready) begin
         out_x_ff <= res_x;
         out_y_ff <= res_y;
         out_z_ff <= res_z;
      end else if (adv) begin
         skid_x_ff <= res_x;
         skid_y_ff <= res_y;
         skid_z_ff <= res_z;
      end else begin
         skid_x_ff <= skid_x_ff;
      end
   end

   assign rsp_chan.valid = out_vld_ff;
   assign rsp_chan.field_x = out_x_ff;
   assign rsp_chan.field_y = out_y_ff;
   assign rsp_chan.field_z = out_z_ff;

   // The skid register only fills behind a full output register.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> out_vld_ff)
      else $error("skid register holds a response while the output is empty");

   // A stalled response is never dropped.
   a_out_held: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && !rsp_chan.ready |=> out_vld_ff)
      else $error("stalled response lost");

   // Write items never reach the blend stages.
   a_write_retires: assert property (@(posedge clock) disable iff (reset)
      adv && vld_ff[3] && (op_ff[3] == OP_WRITE) |=> !vld_ff[4])
      else $error("write item passed the store stage");

   // While the skid register is full nothing in the pipeline moves.
   a_skid_freeze: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |=> $stable(vld_ff) || !$past(skid_vld_ff))
      else $error("pipeline moved while stalled");
endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
   import tfi_pkg::*;

   localparam int NX = 32;
   localparam int NY = 32;
   localparam int NZ = 64;
   localparam int DRAIN_CYCLES = 20;
   localparam int IDLE_LIMIT = 4000;

   typedef struct {
      opcode_type             op;
      logic signed [PosW-1:0] px;
      logic signed [PosW-1:0] py;
      logic signed [PosW-1:0] pz;
      addr_type               idx;
      field_type              bx;
      field_type              by;
      field_type              bz;
   } grid_item_type;

   typedef struct {
      field_type fx;
      field_type fy;
      field_type fz;
   } field_vec_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CsrIdxW-1:0] csr_index;
   logic [CsrDataW-1:0] csr_wdata;

   tfi_req_if req_bus ();
   tfi_rsp_if rsp_bus ();

   trilinear_field_interpolation dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus)
   );

   // Shadow of the grid store and the configuration registers.
   field_type grid_val [3][StoreDepth];
   bit written [StoreDepth];
   logic signed [PosW-1:0] origin [3];
   logic [CsrDataW-1:0] recip [3];

   grid_item_type pending_items[$];
   field_vec_type expected_fields[$];

   int gap_left;
   int hold_left;
   bit hold_done;
   int cycle_count;
   int idle_cycles;
   int mismatches;
   int fields_checked;
   int n_queries;
   int n_writes;
   int n_csr;

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Quiet phases let both sides run without idling.
   function automatic bit calm_phase();
      return cycle_count[9];
   endfunction

   function automatic int next_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm_phase()) return 0;
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(5, 30);
   endfunction

   // Scale one coordinate to grid units and split it into cell and weight.
   function automatic void scale_axis(input logic signed [PosW-1:0] p,
                                      input logic signed [PosW-1:0] o,
                                      input logic [CsrDataW-1:0] rs, input int n,
                                      output int cix, output longint w);
      longint diff;
      logic [63:0] d;
      logic [63:0] f;
      logic [63:0] top;
      diff = longint'(p) - longint'(o);
      f = 64'd0;
      top = 64'(n - 1) << 16;
      if (diff > 0) begin
         d = 64'(diff);
         f = (d * {32'd0, rs}) >> 16;
      end
      if (f > top) f = top;
      cix = int'(f >> 16);
      if (cix >= n - 1) cix = n - 2;
      w = longint'(f) - (longint'(cix) << 16);
   endfunction

   function automatic longint mix(input longint a, input longint b, input longint w);
      return a * (64'sd65536 - w) + b * w;
   endfunction

   function automatic field_type blend_component(input int comp, input int addr[8],
                                                 input longint wx, input longint wy,
                                                 input longint wz);
      longint zl [4];
      longint y0;
      longint y1;
      longint r;
      for (int k = 0; k < 4; k++)
         zl[k] = mix(longint'(grid_val[comp][addr[2*k]]),
                     longint'(grid_val[comp][addr[2*k+1]]), wz);
      y0 = (mix(zl[0], zl[1], wy) + (64'sd1 <<< 15)) >>> 16;
      y1 = (mix(zl[2], zl[3], wy) + (64'sd1 <<< 15)) >>> 16;
      r = (mix(y0, y1, wx) + (64'sd1 <<< 31)) >>> 32;
      return field_type'(r[FieldW-1:0]);
   endfunction

   function automatic void corner_addrs(input grid_item_type it, output int addr[8],
                                        output longint wx, output longint wy,
                                        output longint wz);
      int ix;
      int iy;
      int iz;
      int cx;
      int cy;
      int cz;
      scale_axis(it.px, origin[0], recip[0], NX, ix, wx);
      scale_axis(it.py, origin[1], recip[1], NY, iy, wy);
      scale_axis(it.pz, origin[2], recip[2], NZ, iz, wz);
      for (int k = 0; k < 8; k++) begin
         cx = ix + ((k >> 2) & 1);
         cy = iy + ((k >> 1) & 1);
         cz = iz + (k & 1);
         addr[k] = ((cx * NY + cy) * NZ + cz) & 16'hFFFF;
      end
   endfunction

   // Store a vector in the shadow grid and queue the write transfer.
   function automatic void push_write(input addr_type idx, input field_type bx,
                                      input field_type by, input field_type bz);
      grid_item_type it;
      it.op = OP_WRITE;
      it.px = $urandom();
      it.py = $urandom();
      it.pz = $urandom();
      it.idx = idx;
      it.bx = bx;
      it.by = by;
      it.bz = bz;
      grid_val[0][idx] = bx;
      grid_val[1][idx] = by;
      grid_val[2][idx] = bz;
      written[idx] = 1'b1;
      pending_items.insert(pending_items.size(), it);
      n_writes++;
   endfunction

   function automatic void push_random_write(input addr_type idx);
      push_write(idx, field_type'($urandom()), field_type'($urandom()),
                 field_type'($urandom()));
   endfunction

   // A query first fills any corner that was never written, then its
   // expected vector is computed from the shadow grid.
   function automatic void push_query(input logic signed [PosW-1:0] px,
                                      input logic signed [PosW-1:0] py,
                                      input logic signed [PosW-1:0] pz);
      grid_item_type it;
      field_vec_type ev;
      int addr [8];
      longint wx;
      longint wy;
      longint wz;
      it.op = OP_QUERY;
      it.px = px;
      it.py = py;
      it.pz = pz;
      it.idx = addr_type'($urandom());
      it.bx = field_type'($urandom());
      it.by = field_type'($urandom());
      it.bz = field_type'($urandom());
      corner_addrs(it, addr, wx, wy, wz);
      for (int k = 0; k < 8; k++)
         if (!written[addr[k]]) push_random_write(addr_type'(addr[k]));
      ev.fx = blend_component(0, addr, wx, wy, wz);
      ev.fy = blend_component(1, addr, wx, wy, wz);
      ev.fz = blend_component(2, addr, wx, wy, wz);
      pending_items.insert(pending_items.size(), it);
      expected_fields.insert(expected_fields.size(), ev);
      n_queries++;
   endfunction

   // Random coordinate: mostly inside the grid, some below, beyond or anywhere.
   function automatic logic signed [PosW-1:0] rand_coord(input int ax, input int n);
      longint span;
      int r;
      if (recip[ax] == 0) span = 1000;
      else span = ((longint'(n - 1) << 32) / longint'(recip[ax])) + 2;
      if (span > 64'sd2147483647) span = 64'sd2147483647;
      r = $urandom_range(0, 9);
      if (r < 7) return origin[ax] + PosW'($urandom_range(0, int'(span)));
      if (r == 7) return origin[ax] - PosW'($urandom_range(1, 100000));
      if (r == 8) return origin[ax] + PosW'(span) + PosW'($urandom_range(0, 100000));
      return $urandom();
   endfunction

   task automatic write_reg(input logic [CsrIdxW-1:0] idx, input logic [CsrDataW-1:0] val);
      case (idx)
         CSR_ORIGIN_X: origin[0] = val;
         CSR_ORIGIN_Y: origin[1] = val;
         CSR_ORIGIN_Z: origin[2] = val;
         CSR_RECIP_X:  recip[0] = val;
         CSR_RECIP_Y:  recip[1] = val;
         CSR_RECIP_Z:  recip[2] = val;
         default: ;
      endcase
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      n_csr++;
   endtask

   task automatic write_all_regs(input logic [CsrDataW-1:0] ox, input logic [CsrDataW-1:0] oy,
                                 input logic [CsrDataW-1:0] oz, input logic [CsrDataW-1:0] rx,
                                 input logic [CsrDataW-1:0] ry, input logic [CsrDataW-1:0] rz);
      write_reg(CSR_ORIGIN_X, ox);
      write_reg(CSR_ORIGIN_Y, oy);
      write_reg(CSR_ORIGIN_Z, oz);
      write_reg(CSR_RECIP_X, rx);
      write_reg(CSR_RECIP_Y, ry);
      write_reg(CSR_RECIP_Z, rz);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Block until every item has been sent and every response checked.
   task automatic wait_idle();
      while (pending_items.size() != 0 || expected_fields.size() != 0 || req_bus.valid)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Queue about count transfers, including the writes that fill new corners.
   task automatic random_items(input int count);
      int start;
      start = n_queries + n_writes;
      while (n_queries + n_writes - start < count) begin
         if ($urandom_range(0, 9) < 7)
            push_query(rand_coord(0, NX), rand_coord(1, NY), rand_coord(2, NZ));
         else
            push_random_write(addr_type'($urandom()));
      end
   endtask

   // Request driver: presents queued items, with random gaps between transfers.
   always @(posedge clock) begin
      grid_item_type it;
      if (reset) begin
         req_bus.valid <= 1'b0;
         gap_left <= 0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (gap_left != 0) begin
            gap_left <= gap_left - 1;
            req_bus.valid <= 1'b0;
         end else if (pending_items.size() != 0) begin
            it = pending_items.pop_front();
            req_bus.valid <= 1'b1;
            req_bus.opcode <= it.op;
            req_bus.pos_x <= it.px;
            req_bus.pos_y <= it.py;
            req_bus.pos_z <= it.pz;
            req_bus.entry_index <= it.idx;
            req_bus.write_bx <= it.bx;
            req_bus.write_by <= it.by;
            req_bus.write_bz <= it.bz;
            gap_left <= next_gap();
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Response monitor: random back-pressure, one long hold-off, field checks.
   always @(posedge clock) begin
      field_vec_type ev;
      cycle_count <= cycle_count + 1;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_left <= 0;
      end else begin
         if (hold_left != 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left <= hold_left - 1;
         end else if (!hold_done && fields_checked == 150) begin
            rsp_bus.ready <= 1'b0;
            hold_left <= 300;
            hold_done <= 1'b1;
         end else if (calm_phase()) begin
            rsp_bus.ready <= 1'b1;
         end else if ($urandom_range(0, 99) < 3) begin
            rsp_bus.ready <= 1'b0;
            hold_left <= $urandom_range(5, 40);
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) < 70);
         end

         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_fields.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("ERROR: unexpected response %0d %0d %0d", rsp_bus.field_x,
                           rsp_bus.field_y, rsp_bus.field_z);
            end else begin
               ev = expected_fields.pop_front();
               if (ev.fx !== rsp_bus.field_x || ev.fy !== rsp_bus.field_y ||
                   ev.fz !== rsp_bus.field_z) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("ERROR: response %0d expected %0d %0d %0d got %0d %0d %0d",
                              fields_checked, ev.fx, ev.fy, ev.fz, rsp_bus.field_x,
                              rsp_bus.field_y, rsp_bus.field_z);
               end
            end
            fields_checked++;
         end
      end
   end

   // Watchdog: cycles with work outstanding but no transfer on either side.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (pending_items.size() == 0 && expected_fields.size() == 0 && !req_bus.valid)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("ERROR: no transfer for %0d cycles", IDLE_LIMIT);
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.opcode = OP_WRITE;
      req_bus.pos_x = '0;
      req_bus.pos_y = '0;
      req_bus.pos_z = '0;
      req_bus.entry_index = '0;
      req_bus.write_bx = '0;
      req_bus.write_by = '0;
      req_bus.write_bz = '0;
      rsp_bus.ready = 1'b0;
      cycle_count = 0;
      hold_done = 1'b0;
      mismatches = 0;
      fields_checked = 0;
      n_queries = 0;
      n_writes = 0;
      n_csr = 0;
      for (int ax = 0; ax < 3; ax++) begin
         origin[ax] = '0;
         recip[ax] = RECIP_RESET;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extreme stored values at both ends of the store, then queries
      // at the origin, below it, beyond the top edge and at the position limits.
      push_write(16'h0000, 24'sh7FFFFF, -24'sh800000, 24'sh000000);
      push_write(16'h0001, -24'sh800000, 24'sh7FFFFF, 24'shFFFFFF);
      push_write(16'hFFFF, 24'sh7FFFFF, 24'sh7FFFFF, -24'sh800000);
      push_write(16'hFFFE, -24'sh800000, -24'sh800000, 24'sh7FFFFF);
      push_query(0, 0, 0);
      push_query(-1, -1, -1);
      push_query(32'sh80000000, 32'sh80000000, 32'sh80000000);
      push_query(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
      push_query(32'sh7FFFFFFF, 0, 32'sh80000000);
      push_query(32'd12800, 32'd25600, 32'd38400);
      push_query(32'd793600, 32'd793600, 32'd1612800);
      push_query(32'd780000, 32'd400, 32'd1600000);
      push_query(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F);
      random_items(300);
      wait_idle();

      // Extreme settings: lowest origins with the largest reciprocal spacing.
      write_all_regs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                     32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      push_query(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
      random_items(100);
      wait_idle();

      // Highest origins with zero reciprocal spacing: every coordinate clamps to zero.
      write_all_regs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0, 32'd0, 32'd0);
      random_items(100);
      wait_idle();

      // Random settings with grids reachable by the position range.
      for (int ph = 0; ph < 3; ph++) begin
         write_all_regs($urandom_range(0, 2000000) - 1000000,
                        $urandom_range(0, 2000000) - 1000000,
                        $urandom_range(0, 2000000) - 1000000,
                        $urandom_range(1 << 14, 1 << 26), $urandom_range(1 << 14, 1 << 26),
                        $urandom_range(1 << 14, 1 << 26));
         random_items(330);
         wait_idle();
      end

      $display("Covered %0d queries and %0d grid writes over %0d register writes;",
               n_queries, n_writes, n_csr);
      $display("%0d responses checked, %0d mismatches.", fields_checked, mismatches);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ----- trilinear_field_interpolation.f -----
design/tfi_pkg.sv
design/tfi_if.sv
design/tfi_axis.sv
design/tfi_bank.sv
design/tfi_blend.sv
design/trilinear_field_interpolation.sv
tb/sv/testbench.sv
